// ===== sv/jfop_pkg.sv =====
// Package for the flat JSON object parser: types, limits and result helpers.
package jfop_pkg;

  localparam int MAX_ENTRIES = 4096;
  localparam int MAX_BYTES   = 65536;
  localparam int PAIR_W      = $clog2(MAX_ENTRIES + 1);
  localparam int BYTE_W      = $clog2(MAX_BYTES + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    K_KEY_BYTE = 3'd0,
    K_KEY_END  = 3'd1,
    K_VALUE    = 3'd2,
    K_ACCEPT   = 3'd3,
    K_REJECT   = 3'd4
  } kind_t;

  typedef enum logic [4:0] {
    PH_OPEN, PH_FIRST, PH_KEYSTART, PH_KEY, PH_ESC, PH_HEX1, PH_SURR_BS,
    PH_SURR_U, PH_HEX2, PH_COLON, PH_VALSTART, PH_MINUS, PH_ZERO, PH_DIGITS,
    PH_AFTERVAL, PH_TRAIL, PH_DEAD
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         key_byte;
    logic signed [63:0] number;
    logic               last_of_run;
  } out_item_t;

  // All results caused by one input byte, in order.
  typedef struct packed {
    logic [2:0]        n;
    kind_t [3:0]       slot_kind;
    logic [3:0][7:0]   slot_byte;
    logic [63:0]       number;
  } bundle_t;

  function automatic bundle_t bundle_add(bundle_t b, kind_t k, logic [7:0] v);
    bundle_t r;
    r = b;
    r.slot_kind[b.n[1:0]] = k;
    r.slot_byte[b.n[1:0]] = v;
    r.n = b.n + 3'd1;
    return r;
  endfunction

  // Appends the UTF-8 encoding of a code point as key bytes.
  function automatic bundle_t utf8_add(bundle_t b, logic [20:0] cp);
    bundle_t r;
    r = b;
    if (cp <= 21'h7F) begin
      r = bundle_add(r, K_KEY_BYTE, cp[7:0]);
    end else if (cp <= 21'h7FF) begin
      r = bundle_add(r, K_KEY_BYTE, {3'b110, cp[10:6]});
      r = bundle_add(r, K_KEY_BYTE, {2'b10, cp[5:0]});
    end else if (cp <= 21'hFFFF) begin
      r = bundle_add(r, K_KEY_BYTE, {4'b1110, cp[15:12]});
      r = bundle_add(r, K_KEY_BYTE, {2'b10, cp[11:6]});
      r = bundle_add(r, K_KEY_BYTE, {2'b10, cp[5:0]});
    end else if (cp <= 21'h10FFFF) begin
      r = bundle_add(r, K_KEY_BYTE, {5'b11110, cp[20:18]});
      r = bundle_add(r, K_KEY_BYTE, {2'b10, cp[17:12]});
      r = bundle_add(r, K_KEY_BYTE, {2'b10, cp[11:6]});
      r = bundle_add(r, K_KEY_BYTE, {2'b10, cp[5:0]});
    end
    return r;
  endfunction

endpackage

// ===== sv/jfop_front.sv =====
// Front end: takes one byte per transfer, runs the parse state machine, emits result bundles.
module jfop_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  jfop_pkg::in_item_t byte_data,
  input  logic              queue_full,
  output logic              push,
  output jfop_pkg::bundle_t bundle
);
  import jfop_pkg::*;

  localparam logic [63:0] MAG_Q = 64'd922337203685477580;

  phase_t              phase, phase_next;
  logic [15:0]         high_unit, high_unit_next;
  logic [15:0]         low_unit, low_unit_next;
  logic [1:0]          hex_count, hex_count_next;
  logic [63:0]         magnitude, magnitude_next;
  logic                is_negative, is_negative_next;
  logic                key_has_bytes, key_has_bytes_next;
  logic [PAIR_W-1:0]   pair_count, pair_count_next;
  logic [BYTE_W-1:0]   byte_count, byte_count_next;

  logic                accept;
  bundle_t             bun;

  function automatic logic is_space(logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A;
  endfunction

  // Bit 4 set means the byte is a hex digit.
  function automatic logic [4:0] hex_value(logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= "0" && b <= "9") r = {1'b1, 4'(b - "0")};
    else if (b >= "a" && b <= "f") r = {1'b1, 4'(b - "a" + 8'd10)};
    else if (b >= "A" && b <= "F") r = {1'b1, 4'(b - "A" + 8'd10)};
    return r;
  endfunction

  assign byte_stall = queue_full;
  assign accept     = byte_valid && !byte_stall;
  assign push       = accept && (bun.n != 3'd0);
  assign bundle     = bun;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_OPEN;
      pair_count <= '0;
      byte_count <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      pair_count <= pair_count_next;
      byte_count <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_unit     <= '0;
      low_unit      <= '0;
      hex_count     <= '0;
      magnitude     <= '0;
      is_negative   <= 1'b0;
      key_has_bytes <= 1'b0;
    end else if (accept) begin
      high_unit     <= high_unit_next;
      low_unit      <= low_unit_next;
      hex_count     <= hex_count_next;
      magnitude     <= magnitude_next;
      is_negative   <= is_negative_next;
      key_has_bytes <= key_has_bytes_next;
    end
  end

  always_comb begin
    logic [7:0]        b;
    logic [4:0]        hv;
    logic [15:0]       unit;
    logic [63:0]       mag_cur;
    logic              neg_cur;
    logic [3:0]        d;
    logic              over;
    logic              do_finish;
    logic              do_after;
    logic [PAIR_W-1:0] pc;
    logic              do_digit;

    b         = byte_data.data_byte;
    hv        = hex_value(b);
    unit      = '0;
    mag_cur   = magnitude;
    neg_cur   = is_negative;
    d         = b[3:0];
    over      = 1'b0;
    do_finish = 1'b0;
    do_after  = 1'b0;
    do_digit  = 1'b0;
    pc        = pair_count;

    bun                = '0;
    phase_next         = phase;
    high_unit_next     = high_unit;
    low_unit_next      = low_unit;
    hex_count_next     = hex_count;
    magnitude_next     = magnitude;
    is_negative_next   = is_negative;
    key_has_bytes_next = key_has_bytes;
    pair_count_next    = pair_count;
    byte_count_next    = byte_count;

    if (byte_data.end_of_input) begin
      bun = bundle_add(bun, (phase == PH_TRAIL) ? K_ACCEPT : K_REJECT, 8'h00);
      phase_next      = PH_OPEN;
      pair_count_next = '0;
      byte_count_next = '0;
    end else if (phase != PH_DEAD) begin
      if (byte_count >= BYTE_W'(MAX_BYTES)) begin
        bun = bundle_add(bun, K_REJECT, 8'h00);
        phase_next = PH_DEAD;
      end else begin
        byte_count_next = byte_count + 1'b1;
        unique case (phase)
          PH_OPEN: begin
            if (!is_space(b)) begin
              if (b == "{") phase_next = PH_FIRST;
              else begin
                bun = bundle_add(bun, K_REJECT, 8'h00);
                phase_next = PH_DEAD;
              end
            end
          end
          PH_FIRST, PH_KEYSTART: begin
            if (!is_space(b)) begin
              if (b == "}" && phase == PH_FIRST) phase_next = PH_TRAIL;
              else if (b == "\"") begin
                key_has_bytes_next = 1'b0;
                phase_next = PH_KEY;
              end else begin
                bun = bundle_add(bun, K_REJECT, 8'h00);
                phase_next = PH_DEAD;
              end
            end
          end
          PH_KEY: begin
            if (b == "\"") begin
              if (!key_has_bytes) begin
                bun = bundle_add(bun, K_REJECT, 8'h00);
                phase_next = PH_DEAD;
              end else begin
                bun = bundle_add(bun, K_KEY_END, 8'h00);
                phase_next = PH_COLON;
              end
            end else if (b < 8'h20) begin
              bun = bundle_add(bun, K_REJECT, 8'h00);
              phase_next = PH_DEAD;
            end else if (b == "\\") begin
              phase_next = PH_ESC;
            end else begin
              bun = bundle_add(bun, K_KEY_BYTE, b);
              key_has_bytes_next = 1'b1;
            end
          end
          PH_ESC: begin
            phase_next = PH_KEY;
            key_has_bytes_next = 1'b1;
            priority if (b == "\"" || b == "\\" || b == "/") begin
              bun = bundle_add(bun, K_KEY_BYTE, b);
            end else if (b == "b") bun = bundle_add(bun, K_KEY_BYTE, 8'h08);
            else if (b == "f") bun = bundle_add(bun, K_KEY_BYTE, 8'h0C);
            else if (b == "n") bun = bundle_add(bun, K_KEY_BYTE, 8'h0A);
            else if (b == "r") bun = bundle_add(bun, K_KEY_BYTE, 8'h0D);
            else if (b == "t") bun = bundle_add(bun, K_KEY_BYTE, 8'h09);
            else if (b == "u") begin
              key_has_bytes_next = key_has_bytes;
              high_unit_next = '0;
              hex_count_next = '0;
              phase_next = PH_HEX1;
            end else begin
              key_has_bytes_next = key_has_bytes;
              bun = bundle_add(bun, K_REJECT, 8'h00);
              phase_next = PH_DEAD;
            end
          end
          PH_HEX1: begin
            if (!hv[4]) begin
              bun = bundle_add(bun, K_REJECT, 8'h00);
              phase_next = PH_DEAD;
            end else begin
              unit = {high_unit[11:0], hv[3:0]};
              high_unit_next = unit;
              hex_count_next = hex_count + 2'd1;
              if (hex_count == 2'd3) begin
                if (unit >= 16'hD800 && unit <= 16'hDBFF) begin
                  phase_next = PH_SURR_BS;
                end else if (unit >= 16'hDC00 && unit <= 16'hDFFF) begin
                  bun = bundle_add(bun, K_REJECT, 8'h00);
                  phase_next = PH_DEAD;
                end else begin
                  bun = utf8_add(bun, {5'd0, unit});
                  key_has_bytes_next = 1'b1;
                  phase_next = PH_KEY;
                end
              end
            end
          end
          PH_SURR_BS: begin
            if (b == "\\") phase_next = PH_SURR_U;
            else begin
              bun = bundle_add(bun, K_REJECT, 8'h00);
              phase_next = PH_DEAD;
            end
          end
          PH_SURR_U: begin
            if (b == "u") begin
              low_unit_next = '0;
              hex_count_next = '0;
              phase_next = PH_HEX2;
            end else begin
              bun = bundle_add(bun, K_REJECT, 8'h00);
              phase_next = PH_DEAD;
            end
          end
          PH_HEX2: begin
            if (!hv[4]) begin
              bun = bundle_add(bun, K_REJECT, 8'h00);
              phase_next = PH_DEAD;
            end else begin
              unit = {low_unit[11:0], hv[3:0]};
              low_unit_next = unit;
              hex_count_next = hex_count + 2'd1;
              if (hex_count == 2'd3) begin
                if (unit < 16'hDC00 || unit > 16'hDFFF) begin
                  bun = bundle_add(bun, K_REJECT, 8'h00);
                  phase_next = PH_DEAD;
                end else begin
                  // High surrogate bits 9:0 above low surrogate bits 9:0, plus 0x10000.
                  bun = utf8_add(bun, {high_unit[9:0], unit[9:0]} + 21'h10000);
                  key_has_bytes_next = 1'b1;
                  phase_next = PH_KEY;
                end
              end
            end
          end
          PH_COLON: begin
            if (!is_space(b)) begin
              if (b == ":") phase_next = PH_VALSTART;
              else begin
                bun = bundle_add(bun, K_REJECT, 8'h00);
                phase_next = PH_DEAD;
              end
            end
          end
          PH_VALSTART, PH_MINUS: begin
            if (phase == PH_VALSTART) begin
              mag_cur = '0;
              neg_cur = 1'b0;
            end
            if (phase == PH_VALSTART && is_space(b)) begin
              phase_next = phase;
            end else if (phase == PH_VALSTART && b == "-") begin
              magnitude_next = '0;
              is_negative_next = 1'b1;
              phase_next = PH_MINUS;
            end else begin
              magnitude_next = mag_cur;
              is_negative_next = neg_cur;
              if (b == "0") phase_next = PH_ZERO;
              else if (b >= "1" && b <= "9") do_digit = 1'b1;
              else begin
                bun = bundle_add(bun, K_REJECT, 8'h00);
                phase_next = PH_DEAD;
              end
            end
          end
          PH_ZERO: begin
            if (b >= "0" && b <= "9") begin
              bun = bundle_add(bun, K_REJECT, 8'h00);
              phase_next = PH_DEAD;
            end else do_finish = 1'b1;
          end
          PH_DIGITS: begin
            if (b >= "0" && b <= "9") do_digit = 1'b1;
            else do_finish = 1'b1;
          end
          PH_AFTERVAL: do_after = 1'b1;
          PH_TRAIL: begin
            if (!is_space(b)) begin
              bun = bundle_add(bun, K_REJECT, 8'h00);
              phase_next = PH_DEAD;
            end
          end
          default: phase_next = phase;
        endcase

        if (do_digit) begin
          // The value stays in range when mag*10+d fits the signed limit.
          over = (mag_cur > MAG_Q) ||
                 (mag_cur == MAG_Q && d > (neg_cur ? 4'd8 : 4'd7));
          if (over) begin
            bun = bundle_add(bun, K_REJECT, 8'h00);
            phase_next = PH_DEAD;
          end else begin
            magnitude_next = (mag_cur << 3) + (mag_cur << 1) + {60'd0, d};
            phase_next = PH_DIGITS;
          end
        end

        if (do_finish) begin
          bun = bundle_add(bun, K_VALUE, 8'h00);
          bun.number = is_negative ? (64'd0 - magnitude) : magnitude;
          pc = pair_count + 1'b1;
          pair_count_next = pc;
          do_after = 1'b1;
        end

        if (do_after) begin
          if (is_space(b)) phase_next = PH_AFTERVAL;
          else if (b == "}") phase_next = PH_TRAIL;
          else if (b == "," && pc < PAIR_W'(MAX_ENTRIES)) phase_next = PH_KEYSTART;
          else begin
            bun = bundle_add(bun, K_REJECT, 8'h00);
            phase_next = PH_DEAD;
          end
        end
      end
    end
  end

endmodule

// ===== sv/jfop_back.sv =====
// Back end: a short bundle queue that hands out one result per transfer.
module jfop_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  jfop_pkg::bundle_t  bundle,
  output logic               queue_full,
  output logic               result_valid,
  input  logic               result_stall,
  output jfop_pkg::out_item_t result
);
  import jfop_pkg::*;

  bundle_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic [1:0]        idx;
  bundle_t           head;
  logic              last;
  logic              take;
  logic              pop;

  assign head         = mem[rd_ptr];
  assign queue_full   = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign result_valid = (count != '0);
  assign last         = ({1'b0, idx} == head.n - 3'd1);
  assign take         = result_valid && !result_stall;
  assign pop          = take && last;

  assign result.kind        = head.slot_kind[idx];
  assign result.key_byte    = head.slot_byte[idx];
  assign result.number      = (head.slot_kind[idx] == K_VALUE) ? head.number : 64'd0;
  assign result.last_of_run = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      idx    <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
        idx    <= '0;
      end else if (take) begin
        idx <= idx + 2'd1;
      end
      count <= count + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= bundle;
  end

endmodule

// ===== sv/json_flat_object_parser.sv =====
// Top level of the streaming parser for flat JSON objects with integer values.
// This block parses a JSON text of the form {"key": integer, ...} arriving one byte per
// transfer, with a final end-of-input transfer that gives the verdict (accept or reject)
// and returns the parser to its start state. Keys are decoded, escapes and surrogate
// pairs included, into UTF-8 key bytes followed by a key-end mark; each integer is
// reported once the byte after its last digit arrives. After a reject every byte is
// dropped until end of input, which always reports a second verdict. The front end
// takes one byte per clock cycle while the queue has room and packs all results caused
// by that byte into a bundle in a four-entry queue; the back end hands out one result
// per cycle while the output is not stalled. A byte causing one result therefore sustains
// one byte per cycle, while a byte decoding to an n-byte UTF-8 sequence is handed out
// as n results, and the input stalls only when the queue fills up.
module json_flat_object_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  jfop_pkg::in_item_t  byte_data,
  output logic                result_valid,
  input  logic                result_stall,
  output jfop_pkg::out_item_t result
);
  import jfop_pkg::*;

  // Bundles from the front end travel to the queue in the back end.
  logic    push;
  logic    queue_full;
  bundle_t bundle;

  jfop_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .queue_full (queue_full),
    .push       (push),
    .bundle     (bundle)
  );

  // The back end serializes each bundle, marking the final result of a transfer.
  jfop_back u_back (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .bundle       (bundle),
    .queue_full   (queue_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
